FILE: hw/rtl/spfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spfr_pkg
// shared types and constants of the scratchpad fill and read port
// ----------------------------------------------------------------------------
package spfr_pkg;

    // decoded slave window and item widths
    localparam int ADDR_DEC_W = 24;
    localparam int DEC_W      = ADDR_DEC_W + 1;
    localparam int BUS_ADDR_W = 32;
    localparam int FETCH_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int HALF_W     = 64;
    localparam int LINE_W     = 2 * HALF_W;
    localparam int LANES      = 16;
    localparam int LANE_SEL_W = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 32;

    // item commands
    localparam logic [1:0] CMD_BUS_WRITE = 2'd0;
    localparam logic [1:0] CMD_BUS_READ  = 2'd1;
    localparam logic [1:0] CMD_FILL_BEAT = 2'd2;

    // configuration register indexes
    localparam logic CFG_FETCH_BASE = 1'b0;
    localparam logic CFG_FILL_BEATS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } spfr_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic finish_read;
    } spfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic read_hit;
    } spfr_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/spfr_lane_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spfr_lane_ram
// one byte lane of the scratchpads, single port, registered read
// ----------------------------------------------------------------------------
module spfr_lane_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [7:0]        wdata,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_data_reg <= mem[addr];
    end

    assign rdata = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/spfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spfr_ctrl
// item sequencer: capture, execute, optional memory read, result hand-off
// ----------------------------------------------------------------------------
module spfr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spfr_pkg::spfr_cmd_t      ctl,
    input  wire spfr_pkg::spfr_stat_t stat
);

    import spfr_pkg::*;

    spfr_state_t state_reg;
    spfr_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        result_set;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        ctl.capture     = 1'b0;
        ctl.execute     = 1'b0;
        ctl.finish_read = 1'b0;
        result_set      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // the item register is free even while a result waits
                in_ready    = 1'b1;
                ctl.capture = in_valid;
                if (ctl.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result slot is free or drains at this edge
                ctl.execute = !out_valid_reg || out_ready;
                if (ctl.execute)
                begin
                    if (stat.read_hit)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        result_set = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                ctl.finish_read = 1'b1;
                result_set      = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = result_set ? 1'b1 : (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/spfr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spfr_datapath
// address decode, fill state, configuration, byte-lane pads and result registers
// ----------------------------------------------------------------------------
module spfr_datapath #(
    parameter int PAD_BYTES     = 16384,
    parameter int PAD_ZERO_BASE = 16384,
    parameter int PAD_ONE_BASE  = 32768,
    parameter int WINDOW_END    = 49152
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spfr_pkg::spfr_cmd_t           ctl,
    output spfr_pkg::spfr_stat_t               stat,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [spfr_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic [1:0]                    cmd,
    input  wire logic [spfr_pkg::BUS_ADDR_W-1:0] bus_addr,
    input  wire logic [spfr_pkg::HALF_W-1:0]   beat_data_low,
    input  wire logic [spfr_pkg::HALF_W-1:0]   beat_data_high,
    output logic      [spfr_pkg::HALF_W-1:0]   read_data_low,
    output logic      [spfr_pkg::HALF_W-1:0]   read_data_high,
    output logic                               addr_miss,
    output logic      [spfr_pkg::FETCH_W-1:0]  fetch_addr,
    output logic                               fetch_request,
    output logic                               fill_done
);

    import spfr_pkg::*;

    localparam int OFF_W     = $clog2(PAD_BYTES);
    localparam int ROW_W     = OFF_W - LANE_SEL_W;
    localparam int LANE_DEPTH = 2 * (PAD_BYTES / LANES);
    localparam int LANE_AW   = ROW_W + 1;

    // captured item
    logic [1:0]            item_cmd_reg;
    logic [BUS_ADDR_W-1:0] item_addr_reg;
    logic [LINE_W-1:0]     item_line_reg;

    // configuration
    logic [FETCH_W-1:0] fetch_base_reg;
    logic [COUNT_W-1:0] fill_beats_reg;

    // fill state
    logic               fill_active_reg;
    logic               fill_active_next;
    logic [COUNT_W-1:0] beat_count_reg;
    logic [COUNT_W-1:0] beat_count_next;
    logic               fill_target_reg;
    logic               fill_target_next;
    logic [OFF_W-1:0]   fill_start_reg;
    logic [OFF_W-1:0]   fill_start_next;

    // results
    logic [HALF_W-1:0]  read_lo_reg;
    logic [HALF_W-1:0]  read_hi_reg;
    logic               miss_reg;
    logic [FETCH_W-1:0] fetch_addr_reg;
    logic               fetch_req_reg;
    logic               done_reg;
    logic [LANE_SEL_W-1:0] rd_shift_reg;

    // decode
    logic [DEC_W-1:0]   dec_addr;
    logic               hit_zero;
    logic               hit_one;
    logic               pad_sel;
    logic [OFF_W-1:0]   bus_off;
    logic               is_bus;
    logic               miss;
    logic               done;
    logic               beat_store;
    logic [COUNT_W-1:0] count_after;
    logic [OFF_W-1:0]   fill_off;
    logic [COUNT_W+LANE_SEL_W-1:0] count_bytes;
    logic [FETCH_W-1:0] fetch_next;

    // lane access
    logic                  mem_we;
    logic [OFF_W-1:0]      mem_off;
    logic                  mem_pad;
    logic [LANE_SEL_W-1:0] mem_shift;
    logic [ROW_W-1:0]      mem_row;
    logic [LANE_AW-1:0]    lane_addr [LANES];
    logic [BYTE_W-1:0]     lane_wdata [LANES];
    logic [BYTE_W-1:0]     lane_rdata [LANES];
    logic [LINE_W-1:0]     rd_line;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_cmd_reg  <= cmd;
            item_addr_reg <= bus_addr;
            item_line_reg <= {beat_data_high, beat_data_low};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_base_reg <= '0;
            fill_beats_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FETCH_BASE: fetch_base_reg <= cfg_data[FETCH_W-1:0];
                CFG_FILL_BEATS: fill_beats_reg <= cfg_data[COUNT_W-1:0];
                default:        fetch_base_reg <= fetch_base_reg;
            endcase
        end
    end

    // window decode on the low 24 address bits
    assign dec_addr = {1'b0, item_addr_reg[ADDR_DEC_W-1:0]};
    assign hit_zero = (dec_addr >= DEC_W'(PAD_ZERO_BASE)) && (dec_addr < DEC_W'(PAD_ONE_BASE));
    assign hit_one  = (dec_addr >= DEC_W'(PAD_ONE_BASE)) && (dec_addr < DEC_W'(WINDOW_END));
    assign pad_sel  = !hit_zero;
    assign bus_off  = hit_zero ? OFF_W'(dec_addr - DEC_W'(PAD_ZERO_BASE))
                               : OFF_W'(dec_addr - DEC_W'(PAD_ONE_BASE));
    assign is_bus   = (item_cmd_reg == CMD_BUS_WRITE) || (item_cmd_reg == CMD_BUS_READ);

    assign stat.read_hit = (item_cmd_reg == CMD_BUS_READ) && (hit_zero || hit_one);

    assign beat_store  = beat_count_reg < fill_beats_reg;
    assign count_bytes = {beat_count_reg, {LANE_SEL_W{1'b0}}};
    assign fill_off    = fill_start_reg + OFF_W'(count_bytes);

    always_comb
    begin
        fill_active_next = fill_active_reg;
        beat_count_next  = beat_count_reg;
        fill_target_next = fill_target_reg;
        fill_start_next  = fill_start_reg;
        miss             = 1'b0;
        done             = 1'b0;
        mem_we           = 1'b0;
        count_after      = beat_count_reg + COUNT_W'(beat_store);
        if (is_bus && !(hit_zero || hit_one))
        begin
            miss = 1'b1;
        end
        else if (item_cmd_reg == CMD_BUS_WRITE)
        begin
            fill_target_next = pad_sel;
            fill_start_next  = bus_off;
            beat_count_next  = '0;
            fill_active_next = (fill_beats_reg != '0);
            done             = (fill_beats_reg == '0);
        end
        else if ((item_cmd_reg == CMD_FILL_BEAT) && fill_active_reg)
        begin
            mem_we          = beat_store;
            beat_count_next = count_after;
            if (count_after >= fill_beats_reg)
            begin
                fill_active_next = 1'b0;
                done             = 1'b1;
            end
        end
    end

    assign fetch_next = fetch_base_reg + FETCH_W'({beat_count_next, {LANE_SEL_W{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b0;
            beat_count_reg  <= '0;
            fill_target_reg <= 1'b0;
            fill_start_reg  <= '0;
        end
        else if (ctl.execute)
        begin
            fill_active_reg <= fill_active_next;
            beat_count_reg  <= beat_count_next;
            fill_target_reg <= fill_target_next;
            fill_start_reg  <= fill_start_next;
        end
    end

    // an unaligned line spans two rows: lanes below the start lane take the next row
    assign mem_off   = mem_we ? fill_off : bus_off;
    assign mem_pad   = mem_we ? fill_target_reg : pad_sel;
    assign mem_shift = mem_off[LANE_SEL_W-1:0];
    assign mem_row   = mem_off[OFF_W-1:LANE_SEL_W];

    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            logic [LANE_SEL_W-1:0] src_idx;
            logic [LANE_SEL_W-1:0] rd_idx;

            assign src_idx       = LANE_SEL_W'(k) - mem_shift;
            assign lane_addr[k]  = {mem_pad,
                                    mem_row + ROW_W'(LANE_SEL_W'(k) < mem_shift)};
            assign lane_wdata[k] = item_line_reg[{src_idx, 3'b000} +: BYTE_W];

            spfr_lane_ram #(
                .DEPTH  (LANE_DEPTH),
                .ADDR_W (LANE_AW)
            ) u_lane (
                .clk   (clk),
                .we    (mem_we && ctl.execute),
                .addr  (lane_addr[k]),
                .wdata (lane_wdata[k]),
                .rdata (lane_rdata[k])
            );

            // result byte k comes from lane start+k
            assign rd_idx = LANE_SEL_W'(k) + rd_shift_reg;
            assign rd_line[k*BYTE_W +: BYTE_W] = lane_rdata[rd_idx];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctl.execute)
        begin
            rd_shift_reg   <= bus_off[LANE_SEL_W-1:0];
            read_lo_reg    <= '0;
            read_hi_reg    <= '0;
            miss_reg       <= miss;
            fetch_addr_reg <= fill_active_next ? fetch_next : '0;
            fetch_req_reg  <= fill_active_next;
            done_reg       <= done;
        end
        else if (ctl.finish_read)
        begin
            read_lo_reg <= rd_line[HALF_W-1:0];
            read_hi_reg <= rd_line[LINE_W-1:HALF_W];
        end
    end

    assign read_data_low  = read_lo_reg;
    assign read_data_high = read_hi_reg;
    assign addr_miss      = miss_reg;
    assign fetch_addr     = fetch_addr_reg;
    assign fetch_request  = fetch_req_reg;
    assign fill_done      = done_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/scratchpad_fill_and_read_port_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scratchpad_fill_and_read_port_core
// two byte scratchpads in a slave window, filled by beats and read by line
// ----------------------------------------------------------------------------
// sequence: an item is captured, then executed; a read hit then waits in the
//   read state for the registered read of the byte-lane memories
// a new item is taken only once the previous one has left execute and read
// a finished result waits in the output register while the next item is taken
// reset: asynchronous, active low; clears fill state, configuration and
//   handshake state; pad contents are undefined until filled
// ----------------------------------------------------------------------------
module scratchpad_fill_and_read_port_core #(
    parameter int PAD_BYTES     = 16384,   // power of two, 256 to 1048576
    parameter int PAD_ZERO_BASE = 16384,
    parameter int PAD_ONE_BASE  = 32768,
    parameter int WINDOW_END    = 49152
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [spfr_pkg::CFG_W-1:0]        cfg_data,
    // item input
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        cmd,
    input  wire logic [spfr_pkg::BUS_ADDR_W-1:0]   bus_addr,
    input  wire logic [spfr_pkg::HALF_W-1:0]       beat_data_low,
    input  wire logic [spfr_pkg::HALF_W-1:0]       beat_data_high,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [spfr_pkg::HALF_W-1:0]       read_data_low,
    output logic      [spfr_pkg::HALF_W-1:0]       read_data_high,
    output logic                                   addr_miss,
    output logic      [spfr_pkg::FETCH_W-1:0]      fetch_addr,
    output logic                                   fetch_request,
    output logic                                   fill_done
);

    import spfr_pkg::*;

    // sequencer commands and datapath status
    spfr_cmd_t  ctl;
    spfr_stat_t stat;

    // controller: takes an item, runs the execute step and, for a read hit,
    // waits in the read state for the lane memories before posting the result
    spfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    // datapath: the pads are sixteen byte lanes so that any unaligned
    // 16-byte line is one access per lane, wrapping within the pad
    spfr_datapath #(
        .PAD_BYTES     (PAD_BYTES),
        .PAD_ZERO_BASE (PAD_ZERO_BASE),
        .PAD_ONE_BASE  (PAD_ONE_BASE),
        .WINDOW_END    (WINDOW_END)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .bus_addr       (bus_addr),
        .beat_data_low  (beat_data_low),
        .beat_data_high (beat_data_high),
        .read_data_low  (read_data_low),
        .read_data_high (read_data_high),
        .addr_miss      (addr_miss),
        .fetch_addr     (fetch_addr),
        .fetch_request  (fetch_request),
        .fill_done      (fill_done)
    );

endmodule
`default_nettype wire
